FILE: src/clli_pkg.sv
// ----------------------------------------------------------------------------
// clli_pkg
// Shared types and constants for the complex table interpolator.
// ----------------------------------------------------------------------------
package clli_pkg;

  // Table geometry.
  localparam int unsigned NUM_TISSUES = 16;
  localparam int unsigned NUM_POINTS  = 64;
  localparam int unsigned TISSUE_W    = $clog2(NUM_TISSUES);
  localparam int unsigned POINT_W     = $clog2(NUM_POINTS);
  localparam int unsigned BANK_DEPTH  = NUM_TISSUES * NUM_POINTS / 2;
  localparam int unsigned BANK_WIDTH  = 48;

  // Field widths.
  localparam int unsigned DATA_W = 24;
  localparam int unsigned FLIP_W = 16;
  localparam int unsigned SPAN_W = 17;

  // Cell divider: the cell index has POINT_W quotient bits.
  localparam int unsigned CELL_REM_W = FLIP_W + POINT_W;

  // Interpolation divider: quotient and dividend widths.
  localparam int unsigned QUO_W = DATA_W + 1;
  localparam int unsigned NUM_W = DATA_W + 1 + SPAN_W;
  localparam int unsigned DIV_W = NUM_W + 1;

  // Queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item modes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_INTERP = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRID_MIN   = 2'd0;
  localparam logic [1:0] CFG_GRID_MAX   = 2'd1;
  localparam logic [1:0] CFG_NUM_POINTS = 2'd2;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [FLIP_W-1:0]  gmin;
    logic [FLIP_W-1:0]  gmax;
    logic [SPAN_W-1:0]  span;
    logic [POINT_W-1:0] nm1;
  } cfg_t;

  // One item in the front pipeline.
  typedef struct packed {
    logic                  load;
    logic [TISSUE_W-1:0]   tissue;
    logic [POINT_W-1:0]    gidx;
    logic [DATA_W-1:0]     ld_re;
    logic [DATA_W-1:0]     ld_im;
    logic                  direct;
    logic                  at_end;
    logic                  clamped;
    logic [CELL_REM_W-1:0] rem;
    logic [POINT_W-1:0]    quo;
  } front_t;

  // One entry of the queue: both cell ends for both lanes.
  typedef struct packed {
    logic [1:0][DATA_W-1:0] x0;
    logic [1:0][DATA_W-1:0] x1;
    logic [FLIP_W-1:0]      frac;
    logic                   direct;
    logic                   clamped;
  } qentry_t;

endpackage

FILE: src/complex_lut_linear_interp_top.sv
// ----------------------------------------------------------------------------
// complex_lut_linear_interp_top
// Throughput: one item per cycle while credits remain and the output is not
// stalled; a 16-entry queue with credit counting decouples the cell-finding
// front from the interpolating back pipeline.
// Reset clears control and configuration; table contents stay undefined.
// ----------------------------------------------------------------------------
module complex_lut_linear_interp_top import clli_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [TISSUE_W-1:0] tissue_i,
  input  logic [POINT_W-1:0]  grid_index_i,
  input  logic [DATA_W-1:0]   load_real_i,
  input  logic [DATA_W-1:0]   load_imag_i,
  input  logic [FLIP_W-1:0]   flip_error_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DATA_W-1:0]   out_real_o,
  output logic [DATA_W-1:0]   out_imag_o,
  output logic                clamped_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [FLIP_W-1:0]   cfg_data_i
);

  logic [FLIP_W-1:0] grid_min_q;
  logic [FLIP_W-1:0] grid_max_q;
  logic [6:0]        num_points_q;
  cfg_t              cfg_q;
  cfg_t              cfg_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_min_q   <= 16'hE000;
      grid_max_q   <= 16'h2000;
      num_points_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_MIN:   grid_min_q   <= cfg_data_i;
        CFG_GRID_MAX:   grid_max_q   <= cfg_data_i;
        CFG_NUM_POINTS: num_points_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Derived grid values: span and the clamped cell count.
  always_comb begin
    cfg_d.gmin = grid_min_q;
    cfg_d.gmax = grid_max_q;
    cfg_d.span = {grid_max_q[FLIP_W-1], grid_max_q}
               - {grid_min_q[FLIP_W-1], grid_min_q};
    if (num_points_q < 7'd2) begin
      cfg_d.nm1 = POINT_W'(1);
    end else if (num_points_q > 7'(NUM_POINTS)) begin
      cfg_d.nm1 = POINT_W'(NUM_POINTS - 1);
    end else begin
      cfg_d.nm1 = POINT_W'(num_points_q - 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gmin <= 16'hE000;
      cfg_q.gmax <= 16'h2000;
      cfg_q.span <= 17'd16384;
      cfg_q.nm1  <= POINT_W'(NUM_POINTS - 1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Credits: interpolate items in the front part or in the queue.
  logic [QCNT_W-1:0] credit_q;
  logic              take;
  logic              push;
  logic              pop;
  logic              q_valid;
  qentry_t           q_in;
  qentry_t           q_out;
  logic [QCNT_W-1:0] q_count;

  assign in_ready_o = (credit_q < QCNT_W'(QUEUE_DEPTH));
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + QCNT_W'(take && (mode_i == MODE_INTERP))
                - QCNT_W'(pop);
    end
  end

  clli_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .mode_i       (mode_i),
    .tissue_i     (tissue_i),
    .grid_index_i (grid_index_i),
    .load_real_i  (load_real_i),
    .load_imag_i  (load_imag_i),
    .flip_error_i (flip_error_i),
    .cfg_i        (cfg_q),
    .push_o       (push),
    .entry_o      (q_in)
  );

  clli_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (q_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_out),
    .count_o (q_count)
  );

  clli_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .entry_i     (q_out),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_real_o  (out_real_o),
    .out_imag_o  (out_imag_o),
    .clamped_o   (clamped_o)
  );

  // Credits never exceed the queue size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("credit count above queue depth");

  // Every queued entry still holds its credit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= credit_q)
    else $error("queue holds more entries than credits taken");

endmodule

FILE: src/clli_ram.sv
// ----------------------------------------------------------------------------
// clli_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module clli_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/clli_front.sv
// ----------------------------------------------------------------------------
// clli_front
// Classifies items, finds the grid cell with a pipelined divider, writes
// load items into the banked table and reads both cell ends for the queue.
// ----------------------------------------------------------------------------
module clli_front import clli_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic                mode_i,
  input  logic [TISSUE_W-1:0] tissue_i,
  input  logic [POINT_W-1:0]  grid_index_i,
  input  logic [DATA_W-1:0]   load_real_i,
  input  logic [DATA_W-1:0]   load_imag_i,
  input  logic [FLIP_W-1:0]   flip_error_i,
  input  cfg_t                cfg_i,
  output logic                push_o,
  output qentry_t             entry_o
);

  // Classify stage, product stage, then one stage per cell bit.
  localparam int unsigned NS = 2 + POINT_W;
  localparam int unsigned BANK_AW = $clog2(BANK_DEPTH);

  front_t          st_d [NS];
  front_t          st_q [NS];
  logic [NS-1:0]   vld_q;

  // Classify against the grid ends and form the offset from grid_min.
  always_comb begin
    logic signed [FLIP_W:0] f_ext;
    logic signed [FLIP_W:0] gmin_ext;
    logic signed [FLIP_W:0] gmax_ext;
    logic signed [FLIP_W:0] diff;
    logic                   below;
    logic                   above;
    f_ext    = {flip_error_i[FLIP_W-1], flip_error_i};
    gmin_ext = {cfg_i.gmin[FLIP_W-1], cfg_i.gmin};
    gmax_ext = {cfg_i.gmax[FLIP_W-1], cfg_i.gmax};
    diff     = f_ext - gmin_ext;
    below    = ($signed(cfg_i.span) <= $signed(17'sd0)) || (f_ext < gmin_ext);
    above    = (f_ext >= gmax_ext);
    st_d[0]         = '0;
    st_d[0].load    = (mode_i == MODE_LOAD);
    st_d[0].tissue  = tissue_i;
    st_d[0].gidx    = grid_index_i;
    st_d[0].ld_re   = load_real_i;
    st_d[0].ld_im   = load_imag_i;
    st_d[0].direct  = below || above;
    st_d[0].at_end  = !below;
    st_d[0].clamped = below || (f_ext > gmax_ext);
    st_d[0].rem     = {{POINT_W{1'b0}}, diff[FLIP_W-1:0]};
  end

  // Scale the offset by the number of cells.
  always_comb begin
    st_d[1]     = st_q[0];
    st_d[1].rem = CELL_REM_W'(st_q[0].rem[FLIP_W-1:0] * cfg_i.nm1);
  end

  // Restoring division by the span, one quotient bit per stage.
  for (genvar i = 0; i < POINT_W; i++) begin : g_cell_div
    localparam int unsigned B = POINT_W - 1 - i;
    logic [CELL_REM_W-1:0] dsh;
    logic                  ge;
    assign dsh = {{POINT_W{1'b0}}, cfg_i.span[FLIP_W-1:0]} << B;
    assign ge  = (st_q[1+i].rem >= dsh);
    always_comb begin
      st_d[2+i]        = st_q[1+i];
      st_d[2+i].rem    = ge ? (st_q[1+i].rem - dsh) : st_q[1+i].rem;
      st_d[2+i].quo[B] = ge;
    end
  end

  // Pipeline registers: valid bits are reset, payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NS; i++) begin
      st_q[i] <= st_d[i];
    end
  end

  // Cell index: the quotient, or an end entry for direct items.
  front_t               last;
  logic [POINT_W-1:0]   cell_idx;
  logic [POINT_W:0]     cell_p1;
  logic [BANK_AW-1:0]   raddr_even;
  logic [BANK_AW-1:0]   raddr_odd;
  logic [BANK_AW-1:0]   waddr;
  logic                 we_even;
  logic                 we_odd;
  logic [BANK_WIDTH-1:0] wdata;
  logic [BANK_WIDTH-1:0] rd_even;
  logic [BANK_WIDTH-1:0] rd_odd;

  assign last = st_q[NS-1];

  always_comb begin
    if (last.direct) begin
      cell_idx = last.at_end ? cfg_i.nm1 : '0;
    end else begin
      cell_idx = last.quo;
    end
  end

  // Even entries live in one bank and odd entries in the other, so a cell's
  // two ends are always read in the same cycle.
  assign cell_p1    = {1'b0, cell_idx} + 1'b1;
  assign raddr_even = {last.tissue, cell_p1[POINT_W-1:1]};
  assign raddr_odd  = {last.tissue, cell_idx[POINT_W-1:1]};
  assign waddr      = {last.tissue, last.gidx[POINT_W-1:1]};
  assign wdata      = {last.ld_re, last.ld_im};
  assign we_even    = vld_q[NS-1] && last.load && !last.gidx[0];
  assign we_odd     = vld_q[NS-1] && last.load && last.gidx[0];

  clli_ram #(
    .WIDTH (BANK_WIDTH),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_even),
    .rdata_o (rd_even)
  );

  clli_ram #(
    .WIDTH (BANK_WIDTH),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_odd),
    .rdata_o (rd_odd)
  );

  // Read stage, aligned with the registered RAM output.
  logic              rd_vld_q;
  logic              rd_k0_q;
  logic [FLIP_W-1:0] rd_frac_q;
  logic              rd_direct_q;
  logic              rd_clamped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[NS-1] && !last.load;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k0_q      <= cell_idx[0];
    rd_frac_q    <= last.rem[FLIP_W-1:0];
    rd_direct_q  <= last.direct;
    rd_clamped_q <= last.clamped;
  end

  // Pick the lower and upper cell ends out of the two banks.
  always_comb begin
    logic [BANK_WIDTH-1:0] lo;
    logic [BANK_WIDTH-1:0] hi;
    lo = rd_k0_q ? rd_odd : rd_even;
    hi = rd_k0_q ? rd_even : rd_odd;
    entry_o.x0[0]   = lo[BANK_WIDTH-1:DATA_W];
    entry_o.x0[1]   = lo[DATA_W-1:0];
    entry_o.x1[0]   = hi[BANK_WIDTH-1:DATA_W];
    entry_o.x1[1]   = hi[DATA_W-1:0];
    entry_o.frac    = rd_frac_q;
    entry_o.direct  = rd_direct_q;
    entry_o.clamped = rd_clamped_q;
  end

  assign push_o = rd_vld_q;

endmodule

FILE: src/clli_queue.sv
// ----------------------------------------------------------------------------
// clli_queue
// Short FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module clli_queue import clli_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qentry_t           entry_i,
  input  logic              pop_i,
  output logic              valid_o,
  output qentry_t           entry_o,
  output logic [QCNT_W-1:0] count_o
);

  qentry_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  // The credit scheme upstream must never overfill the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < QCNT_W'(QUEUE_DEPTH))
    else $error("queue push while full");

  // A pop is only issued against a stored entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue pop while empty");

endmodule

FILE: src/clli_back.sv
// ----------------------------------------------------------------------------
// clli_back
// Interpolates between the cell ends: difference, product, rounding offset,
// a pipelined signed floor division and the final add, on two lanes.
// ----------------------------------------------------------------------------
module clli_back import clli_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  qentry_t           entry_i,
  output logic              pop_o,
  input  cfg_t              cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_real_o,
  output logic [DATA_W-1:0] out_imag_o,
  output logic              clamped_o
);

  // Stage map: 0 diff, 1 product, 2 offset, 3 magnitude, then the divider,
  // then the sign fix-up stage.
  localparam int unsigned DIV0 = 4;
  localparam int unsigned DLST = DIV0 + QUO_W - 1;
  localparam int unsigned FIN  = DLST + 1;
  localparam int unsigned NB   = FIN + 1;

  logic              adv;
  logic [NB-1:0]     bv_q;
  logic [NB-1:0]     bdir_q;
  logic [NB-1:0]     bclp_q;
  logic [SPAN_W-1:0] dvs;
  logic [DATA_W-1:0] res_d [2];
  logic [DATA_W-1:0] res_q [2];
  logic              out_valid_q;
  logic              out_clp_q;

  // The whole back part moves when the output register is empty or its result is taken.
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = q_valid_i && adv;
  assign dvs   = {cfg_i.span[FLIP_W-1:0], 1'b0};

  // Control pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      bv_q        <= {bv_q[NB-2:0], q_valid_i};
      out_valid_q <= bv_q[NB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bdir_q <= {bdir_q[NB-2:0], entry_i.direct};
      bclp_q <= {bclp_q[NB-2:0], entry_i.clamped};
    end
  end

  // One lane each for the in-phase and quadrature parts.
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DATA_W-1:0] x0_q [NB];
    logic [QUO_W-1:0]  diff_q;
    logic [FLIP_W-1:0] frac_q;
    logic [NUM_W-1:0]  num_q;
    logic [DIV_W-1:0]  n_q;
    logic [DIV_W-1:0]  rem_q [DIV0-1:DLST];
    logic [QUO_W-1:0]  quo_q [DIV0-1:DLST];
    logic              neg_q [DIV0-1:DLST];
    logic [DIV_W-1:0]  rem_d [DIV0:DLST];
    logic [QUO_W-1:0]  quo_d [DIV0:DLST];
    logic [QUO_W-1:0]  qs_q;
    logic [QUO_W-1:0]  qs_d;

    // Restoring division of the magnitude by twice the span.
    for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int unsigned B = QUO_W - 1 - j;
      logic [DIV_W-1:0] dsh;
      logic             ge;
      assign dsh = {{(DIV_W-SPAN_W){1'b0}}, dvs} << B;
      assign ge  = (rem_q[DIV0-1+j] >= dsh);
      always_comb begin
        rem_d[DIV0+j]    = ge ? (rem_q[DIV0-1+j] - dsh) : rem_q[DIV0-1+j];
        quo_d[DIV0+j]    = quo_q[DIV0-1+j];
        quo_d[DIV0+j][B] = ge;
      end
    end

    // Floor of a negative quotient: minus the quotient, one lower when
    // the division left a remainder.
    assign qs_d = neg_q[DLST] ? (~quo_q[DLST] + QUO_W'(rem_q[DLST] == '0))
                              : quo_q[DLST];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        x0_q[0] <= entry_i.x0[l];
        for (int i = 1; i < NB; i++) begin
          x0_q[i] <= x0_q[i-1];
        end
        diff_q <= {entry_i.x1[l][DATA_W-1], entry_i.x1[l]}
                - {entry_i.x0[l][DATA_W-1], entry_i.x0[l]};
        frac_q <= entry_i.frac;
        num_q  <= NUM_W'($signed(diff_q) * $signed({1'b0, frac_q}));
        n_q    <= {num_q, 1'b0}
                + {{(DIV_W-FLIP_W){1'b0}}, cfg_i.span[FLIP_W-1:0]};
        neg_q[DIV0-1] <= n_q[DIV_W-1];
        rem_q[DIV0-1] <= n_q[DIV_W-1] ? (~n_q + 1'b1) : n_q;
        quo_q[DIV0-1] <= '0;
        for (int i = DIV0; i <= DLST; i++) begin
          rem_q[i] <= rem_d[i];
          quo_q[i] <= quo_d[i];
          neg_q[i] <= neg_q[i-1];
        end
        qs_q <= qs_d;
      end
    end

    // Direct items pass the end entry through unchanged.
    assign res_d[l] = bdir_q[FIN] ? x0_q[FIN] : (x0_q[FIN] + qs_q[DATA_W-1:0]);
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q[0]  <= res_d[0];
      res_q[1]  <= res_d[1];
      out_clp_q <= bclp_q[FIN];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_real_o  = res_q[0];
  assign out_imag_o  = res_q[1];
  assign clamped_o   = out_clp_q;

  // A result held at the output freezes the whole back pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(bv_q))
    else $error("back pipeline moved during an output stall");

endmodule
